// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, reset excluded.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset excluded.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/aes_pkg.sv =====
`default_nettype none
package aes_pkg;

    localparam int unsigned KEY_WORDS   = 8;
    localparam int unsigned SCHED_WORDS = 60;
    localparam int unsigned LAST_ROUND  = 14;
    localparam int unsigned CFG_IDX_W   = 2;

    typedef logic [127:0] t_block;
    typedef logic [5:0]   t_rk_addr;
    typedef logic [3:0]   t_round;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXP_LOAD,
        ST_EXP_GEN,
        ST_RUN,
        ST_DONE
    } t_state;

    // Round unit controls
    typedef struct packed {
        logic inverse;
        logic first;
        logic last;
    } t_rnd_ctl;

    localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] v);
        xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage
`default_nettype wire

// ===== hdl/aes_if.sv =====
`default_nettype none
interface aes_blk_if;
    logic         valid;
    logic         ready;
    logic         mode;
    logic [63:0]  block_high;
    logic [63:0]  block_low;
    modport source (output valid, mode, block_high, block_low, input ready);
    modport sink   (input valid, mode, block_high, block_low, output ready);
endinterface

interface aes_res_if;
    logic         valid;
    logic         ready;
    logic [63:0]  result_high;
    logic [63:0]  result_low;
    modport source (output valid, result_high, result_low, input ready);
    modport sink   (input valid, result_high, result_low, output ready);
endinterface

interface aes_cfg_if;
    logic         valid;
    logic         ready;
    logic [1:0]   index;
    logic [63:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/aes_ram.sv =====
`default_nettype none
module aes_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 60
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/aes_round.sv =====
`default_nettype none
// One cipher round on the full state; shared by all 15 round steps (initial key add and 14 rounds).
module aes_round (
    input  wire              [127:0] i_state,
    input  wire              [127:0] i_rkey,
    input  wire aes_pkg::t_rnd_ctl   i_ctl,
    output logic             [127:0] o_state
);
    logic [7:0] s   [16];
    logic [7:0] ss  [16];
    logic [7:0] ak  [16];
    logic [7:0] mx  [16];
    logic [7:0] b0, b1, b2, b3, x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            s[i] = i_state[127-8*i -: 8];
        end
        // sub/shift, forward or inverse
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (i_ctl.inverse) begin
                    ss[c*4+r] = aes_pkg::INV_SBOX[s[((c+4-r)%4)*4+r]];
                end else begin
                    ss[c*4+r] = aes_pkg::SBOX[s[((c+r)%4)*4+r]];
                end
            end
        end
        for (int i = 0; i < 16; i++) begin
            if (i_ctl.first) begin
                ak[i] = s[i] ^ i_rkey[127-8*i -: 8];
            end else if (i_ctl.inverse) begin
                ak[i] = ss[i] ^ i_rkey[127-8*i -: 8];
            end else begin
                ak[i] = ss[i];
            end
        end
        for (int c = 0; c < 4; c++) begin
            b0 = ak[c*4]; b1 = ak[c*4+1]; b2 = ak[c*4+2]; b3 = ak[c*4+3];
            x0 = aes_pkg::xtime(b0); x1 = aes_pkg::xtime(b1);
            x2 = aes_pkg::xtime(b2); x3 = aes_pkg::xtime(b3);
            y0 = aes_pkg::xtime(x0); y1 = aes_pkg::xtime(x1);
            y2 = aes_pkg::xtime(x2); y3 = aes_pkg::xtime(x3);
            z0 = aes_pkg::xtime(y0); z1 = aes_pkg::xtime(y1);
            z2 = aes_pkg::xtime(y2); z3 = aes_pkg::xtime(y3);
            if (i_ctl.inverse) begin
                // 0e 0b 0d 09
                mx[c*4]   = (z0^y0^x0) ^ (z1^x1^b1) ^ (z2^y2^b2) ^ (z3^b3);
                mx[c*4+1] = (z0^b0) ^ (z1^y1^x1) ^ (z2^x2^b2) ^ (z3^y3^b3);
                mx[c*4+2] = (z0^y0^b0) ^ (z1^b1) ^ (z2^y2^x2) ^ (z3^x3^b3);
                mx[c*4+3] = (z0^x0^b0) ^ (z1^y1^b1) ^ (z2^b2) ^ (z3^y3^x3);
            end else begin
                mx[c*4]   = x0 ^ (x1^b1) ^ b2 ^ b3;
                mx[c*4+1] = b0 ^ x1 ^ (x2^b2) ^ b3;
                mx[c*4+2] = b0 ^ b1 ^ x2 ^ (x3^b3);
                mx[c*4+3] = (x0^b0) ^ b1 ^ b2 ^ x3;
            end
        end
        for (int i = 0; i < 16; i++) begin
            if (i_ctl.first) begin
                o_state[127-8*i -: 8] = ak[i];
            end else if (i_ctl.inverse) begin
                o_state[127-8*i -: 8] = i_ctl.last ? ak[i] : mx[i];
            end else begin
                o_state[127-8*i -: 8] = (i_ctl.last ? ak[i] : mx[i]) ^ i_rkey[127-8*i -: 8];
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/aes256_block_cipher.sv =====
`default_nettype none
// Channel   Dir  Payload                      Transfer
// i_blk     in   mode, block_high, block_low  valid & ready
// o_res     out  result_high, result_low      valid & ready
// i_cfg     in   index[1:0], data[63:0]       valid & ready
//
// Per round: four 32-bit store reads, the round applied with the fourth word
// straight off the store; after 15 rounds the result is valid, and the state
// passes through ST_DONE back to idle before another block is taken.
// The key store's single read port sets the pace of a round.
// Key expansion runs with the first block after a key write or reset, before that
// block is processed. Reset clears control and the key registers only.
// The result is held until taken; no new block is taken meanwhile.
module aes256_block_cipher (
    input  wire     i_clk,
    input  wire     i_rst_n,
    aes_blk_if.sink   i_blk,
    aes_res_if.source o_res,
    aes_cfg_if.sink   i_cfg
);
    logic [63:0] r_key [4];
    logic        r_expanded;
    aes_pkg::t_state r_state, n_state;

    logic [5:0]  r_widx, n_widx;     // expansion write index
    logic [7:0]  r_rcon, n_rcon;
    logic        r_phase, n_phase;   // expansion: read i-8 then write
    logic [31:0] r_prev, n_prev;     // word i-1
    logic [3:0]  r_round, n_round;   // round step 0..14
    logic [2:0]  r_sub, n_sub;       // word fetch 0..4
    logic        r_mode;
    logic [127:0] r_st;
    logic [95:0] r_rk;               // round-key words 0..2; word 3 taken off the store
    logic        r_out_valid, n_out_valid;

    logic        we;
    logic [5:0]  waddr, raddr;
    logic [31:0] wdata, rdata, t;
    logic [3:0]  rk_round;
    logic [1:0]  rk_slot;
    logic [127:0] rnd_out;
    aes_pkg::t_rnd_ctl ctl;

    assign i_cfg.ready = (r_state == aes_pkg::ST_IDLE) && !r_out_valid;
    assign i_blk.ready = (r_state == aes_pkg::ST_IDLE) && !r_out_valid && !i_cfg.valid;
    assign o_res.valid = r_out_valid;
    assign o_res.result_high = r_st[127:64];
    assign o_res.result_low  = r_st[63:0];

    aes_ram #(.WIDTH(32), .DEPTH(aes_pkg::SCHED_WORDS)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    aes_round u_round (.i_state(r_st), .i_rkey({r_rk, rdata}), .i_ctl(ctl), .o_state(rnd_out));

    // round number used by the current step
    assign rk_round = r_mode ? 4'(aes_pkg::LAST_ROUND - r_round) : r_round;
    assign rk_slot  = 2'(r_sub - 3'd1);
    assign ctl.inverse = r_mode;
    assign ctl.first   = (r_round == 4'd0);
    assign ctl.last    = (r_round == 4'(aes_pkg::LAST_ROUND));

    // schedule word i from word i-8 (rdata) and word i-1
    always_comb begin
        if (r_widx[2:0] == 3'd0) begin
            t = aes_pkg::sub_word({r_prev[23:0], r_prev[31:24]}) ^ {r_rcon, 24'd0};
        end else if (r_widx[2:0] == 3'd4) begin
            t = aes_pkg::sub_word(r_prev);
        end else begin
            t = r_prev;
        end
    end

    always_comb begin
        we = 1'b0;
        waddr = r_widx;
        wdata = rdata ^ t;
        raddr = {rk_round, r_sub[1:0]};
        n_state = r_state;
        n_widx = r_widx; n_rcon = r_rcon; n_phase = r_phase; n_prev = r_prev;
        n_round = r_round; n_sub = r_sub;
        n_out_valid = r_out_valid;
        if (o_res.valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            aes_pkg::ST_IDLE: begin
                if (i_blk.valid && i_blk.ready) begin
                    n_round = 4'd0; n_sub = 3'd0;
                    n_widx = 6'd0; n_rcon = 8'h01; n_phase = 1'b0;
                    n_state = r_expanded ? aes_pkg::ST_RUN : aes_pkg::ST_EXP_LOAD;
                end
            end
            aes_pkg::ST_EXP_LOAD: begin
                we = 1'b1;
                wdata = r_widx[0] ? r_key[r_widx[2:1]][31:0] : r_key[r_widx[2:1]][63:32];
                n_prev = wdata;
                n_widx = r_widx + 6'd1;
                if (r_widx == 6'(aes_pkg::KEY_WORDS - 1)) begin
                    n_state = aes_pkg::ST_EXP_GEN;
                end
            end
            aes_pkg::ST_EXP_GEN: begin
                raddr = r_widx - 6'(aes_pkg::KEY_WORDS);
                if (!r_phase) begin
                    n_phase = 1'b1;
                end else begin
                    we = 1'b1;
                    n_prev = wdata;
                    n_phase = 1'b0;
                    if (r_widx[2:0] == 3'd0) begin
                        n_rcon = aes_pkg::xtime(r_rcon);
                    end
                    n_widx = r_widx + 6'd1;
                    if (r_widx == 6'(aes_pkg::SCHED_WORDS - 1)) begin
                        n_state = aes_pkg::ST_RUN;
                    end
                end
            end
            aes_pkg::ST_RUN: begin
                // sub 0..3 issue reads, 1..3 capture, 4 applies the round
                if (r_sub == 3'd4) begin
                    n_sub = 3'd0;
                    n_round = r_round + 4'd1;
                    if (r_round == 4'(aes_pkg::LAST_ROUND)) begin
                        n_out_valid = 1'b1;
                        n_state = aes_pkg::ST_DONE;
                    end
                end else begin
                    n_sub = r_sub + 3'd1;
                end
            end
            aes_pkg::ST_DONE: begin
                n_state = aes_pkg::ST_IDLE;
            end
            default: n_state = aes_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aes_pkg::ST_IDLE;
            r_expanded <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 4; k++) r_key[k] <= 64'd0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == aes_pkg::ST_EXP_GEN && n_state == aes_pkg::ST_RUN) begin
                r_expanded <= 1'b1;
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_key[i_cfg.index] <= i_cfg.data;
                r_expanded <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_widx <= n_widx; r_rcon <= n_rcon; r_phase <= n_phase; r_prev <= n_prev;
        r_round <= n_round; r_sub <= n_sub;
        if (i_blk.valid && i_blk.ready) begin
            r_mode <= i_blk.mode;
            r_st <= {i_blk.block_high, i_blk.block_low};
        end else if (r_state == aes_pkg::ST_RUN) begin
            if (r_sub != 3'd0 && r_sub != 3'd4) begin
                r_rk[95-32*rk_slot -: 32] <= rdata;
            end
            if (r_sub == 3'd4) begin
                r_st <= rnd_out;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hdl/aes_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module aes_prop_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire blk_valid,
    input wire blk_ready,
    input wire res_valid,
    input wire res_ready,
    input wire cfg_valid,
    input wire cfg_ready
);
    `CHK_IMPL(a_no_blk_while_res, i_clk, i_rst_n, res_valid, !blk_ready, "block taken with result pending")
    `CHK_NEXT(a_busy_after_blk, i_clk, i_rst_n, blk_valid && blk_ready, !blk_ready && !cfg_ready, "ready after block transfer")
    `CHK_IMPL(a_cfg_idle, i_clk, i_rst_n, cfg_ready, !res_valid, "config ready while result pending")
    `CHK_NEXT(a_res_hold, i_clk, i_rst_n, res_valid && !res_ready, res_valid, "result dropped")
endmodule

bind aes256_block_cipher aes_prop_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .blk_valid(i_blk.valid), .blk_ready(i_blk.ready),
    .res_valid(o_res.valid), .res_ready(o_res.ready),
    .cfg_valid(i_cfg.valid), .cfg_ready(i_cfg.ready)
);
`default_nettype wire
